// File: rtl/ets_pkg.sv
package ets_pkg;

  localparam int MAX_TERMS_DEF = 32;

  // Field widths
  localparam int X_W     = 20;
  localparam int CFG_W   = 6;
  localparam int EXP_W   = 32;
  localparam int FRAC_W  = 16;

  // Term magnitudes stay below 2^28 for any 20-bit argument (|x| <= 8).
  localparam int MAG_W   = 28;
  localparam int TERM_W  = MAG_W + 1;
  localparam int PROD_W  = TERM_W + X_W;
  localparam int Q_W     = PROD_W - FRAC_W;
  // Accumulator holds up to 1023 full-range terms plus the constant one without wrapping.
  localparam int SUM_W   = EXP_W + 7;

  localparam logic [CFG_W-1:0]          NUM_TERMS_RST = CFG_W'(8);
  localparam logic signed [TERM_W-1:0]  ONE_TERM = TERM_W'(65536);
  localparam logic signed [SUM_W-1:0]   ONE_SUM  = SUM_W'(65536);
  localparam logic signed [SUM_W-1:0]   SUM_MAX  = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0]   SUM_MIN  = -SUM_W'(64'sd2147483648);

  // Item between a divide stage and the next multiply stage
  typedef struct packed {
    logic                     vld;
    logic signed [X_W-1:0]    x;
    logic signed [TERM_W-1:0] term;
    logic signed [SUM_W-1:0]  sum;
    logic                     sat;
  } ets_lane_t;

  // Item between a multiply stage and its divide stage
  typedef struct packed {
    logic                     vld;
    logic signed [X_W-1:0]    x;
    logic                     neg;
    logic [MAG_W-1:0]         mag;
    logic signed [SUM_W-1:0]  sum;
    logic                     sat;
  } ets_prod_t;

endpackage

// File: rtl/exp_taylor_series.sv
// Truncated Taylor sum of exp(x): x is signed Q3.16, the result signed Q15.16
// over cfg num_terms terms (0 counts as 1, values above MAX_TERMS as
// MAX_TERMS). Each term after the constant one has a pipeline pair of its own:
// a multiply by x with a floor shift, then a divide by the term index through
// a reciprocal multiply, with the running sum added there. One item enters per
// cycle, and the whole pipeline holds while a result waits under out_stall.
// Write num_terms only with the pipeline empty. out_saturated flags a clamped
// term or sum.
module exp_taylor_series
  import ets_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [X_W-1:0]   in_x_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [EXP_W-1:0] out_exp_value,
  output logic                    out_saturated,
  input  logic                    cfg_wr_en,
  input  logic [CFG_W-1:0]        cfg_wr_data
);

  localparam int NW     = $clog2(MAX_TERMS + 1);
  localparam int STAGES = MAX_TERMS - 1;

  logic [CFG_W-1:0]        num_terms_r;
  logic [NW-1:0]           n_eff;
  logic                    adv;
  ets_lane_t               lane_in_r;
  ets_lane_t               lanes [STAGES+1];
  ets_prod_t               prods [STAGES];
  ets_lane_t               last;
  logic                    out_valid_r;
  logic signed [EXP_W-1:0] exp_r;
  logic signed [EXP_W-1:0] exp_nxt;
  logic                    sat_r;
  logic                    sat_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_terms_r <= NUM_TERMS_RST;
    end else if (cfg_wr_en) begin
      num_terms_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (num_terms_r == '0) begin
      n_eff = NW'(1);
    end else if (32'(num_terms_r) > 32'(MAX_TERMS)) begin
      n_eff = NW'(MAX_TERMS);
    end else begin
      n_eff = NW'(num_terms_r);
    end
  end

  // Advance everything unless a finished item is held
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_in_r.vld <= 1'b0;
    end else if (adv) begin
      lane_in_r.vld  <= in_valid;
      lane_in_r.x    <= in_x_value;
      lane_in_r.term <= ONE_TERM;
      lane_in_r.sum  <= ONE_SUM;
      lane_in_r.sat  <= 1'b0;
    end
  end

  assign lanes[0] = lane_in_r;

  for (genvar g = 0; g < STAGES; g++) begin : g_term
    ets_mul_stage u_mul (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .lane_i (lanes[g]),
      .prod_o (prods[g])
    );

    ets_div_stage #(
      .TERM_IDX (g + 1),
      .NW       (NW)
    ) u_div (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .n_eff  (n_eff),
      .prod_i (prods[g]),
      .lane_o (lanes[g+1])
    );
  end

  assign last = lanes[STAGES];

  always_comb begin
    sat_nxt = last.sat;
    if (last.sum > SUM_MAX) begin
      exp_nxt = EXP_W'(SUM_MAX);
      sat_nxt = 1'b1;
    end else if (last.sum < SUM_MIN) begin
      exp_nxt = EXP_W'(SUM_MIN);
      sat_nxt = 1'b1;
    end else begin
      exp_nxt = EXP_W'(last.sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= last.vld;
      exp_r       <= exp_nxt;
      sat_r       <= sat_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_exp_value = exp_r;
  assign out_saturated = sat_r;

endmodule

// File: rtl/ets_mul_stage.sv
module ets_mul_stage
  import ets_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  ets_lane_t lane_i,
  output ets_prod_t prod_o
);

  logic signed [PROD_W-1:0] prod;
  logic signed [Q_W-1:0]    q;
  logic [Q_W-1:0]           mag_full;
  ets_prod_t                prod_nxt;
  ets_prod_t                prod_r;

  // Floor shift: the upper bits of the two's complement product
  assign prod     = $signed(lane_i.term) * $signed(lane_i.x);
  assign q        = prod[PROD_W-1:FRAC_W];
  assign mag_full = q[Q_W-1] ? Q_W'(-q) : Q_W'(q);

  always_comb begin
    prod_nxt.vld = lane_i.vld;
    prod_nxt.x   = lane_i.x;
    prod_nxt.neg = q[Q_W-1];
    prod_nxt.sum = lane_i.sum;
    prod_nxt.sat = lane_i.sat;
    if (|mag_full[Q_W-1:MAG_W]) begin
      prod_nxt.mag = '1;
      prod_nxt.sat = 1'b1;
    end else begin
      prod_nxt.mag = mag_full[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r.vld <= 1'b0;
    end else if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_o = prod_r;

endmodule

// File: rtl/ets_div_stage.sv
module ets_div_stage
  import ets_pkg::*;
#(
  parameter int TERM_IDX = 1,
  parameter int NW       = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [NW-1:0] n_eff,
  input  ets_prod_t     prod_i,
  output ets_lane_t     lane_o
);

  // Reciprocal exact for any MAG_W-bit dividend
  localparam int SH = MAG_W + $clog2(TERM_IDX);
  localparam logic [MAG_W:0] RM =
    (MAG_W+1)'(((64'd1 << SH) + 64'(TERM_IDX) - 64'd1) / 64'(TERM_IDX));
  localparam int RP_W = 2 * MAG_W + 1;

  logic [RP_W-1:0]          rprod;
  logic [MAG_W-1:0]         quo;
  logic signed [TERM_W-1:0] term;
  logic                     active;
  ets_lane_t                lane_nxt;
  ets_lane_t                lane_r;

  assign rprod  = RP_W'(prod_i.mag) * RP_W'(RM);
  assign quo    = MAG_W'(rprod >> SH);
  // Truncate toward zero: divide the magnitude, then restore the sign
  assign term   = prod_i.neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign active = 32'(TERM_IDX) < 32'(n_eff);

  always_comb begin
    lane_nxt.vld  = prod_i.vld;
    lane_nxt.x    = prod_i.x;
    lane_nxt.term = term;
    lane_nxt.sat  = prod_i.sat;
    lane_nxt.sum  = prod_i.sum;
    if (active) begin
      lane_nxt.sum = prod_i.sum + SUM_W'(term);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.vld <= 1'b0;
    end else if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

// File: rtl/ets_checker.sv
module ets_checker
  import ets_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [EXP_W-1:0] out_exp_value,
  input logic                    out_saturated
);

  // Held result stays on the port
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_exp_value))
    else $error("held result changed");

  // Input side stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // No clamp is reachable with a 20-bit argument
  a_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_saturated)
    else $error("unexpected saturation");

  // Pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

endmodule

bind exp_taylor_series ets_checker u_ets_checker (.*);
